[rtl/shabc_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 block compression package
// Shared word types, round constants, initial hash value and round functions.
// ----------------------------------------------------------------------------
package shabc_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_IV     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int ROUND_W    = 6;
  localparam int POS_W      = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [7:0]       word8_t;
  typedef word_t [15:0]      word16_t;

  typedef struct packed {
    logic               shift_in;
    logic               init;
    logic               step;
    logic [ROUND_W-1:0] sched_idx;
  } core_ctrl_t;

  localparam word_t IV_RESET [NUM_IV] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/shabc_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 round core
// Sixteen-word schedule shift line, pre-added schedule word and the working
// variables, advanced by one shared round datapath in each cycle with ctrl.step set.
// ----------------------------------------------------------------------------
module shabc_core (
  input  logic                clk,
  input  shabc_pkg::core_ctrl_t ctrl,
  input  shabc_pkg::word_t    word_in,
  input  shabc_pkg::word8_t   chain,
  output shabc_pkg::word8_t   vars
);

  shabc_pkg::word16_t win;
  shabc_pkg::word_t   wk;
  shabc_pkg::word8_t  v;
  shabc_pkg::word8_t  v_next;
  shabc_pkg::word_t   sched_w;
  shabc_pkg::word_t   t1;
  shabc_pkg::word_t   t2;

  // The oldest word sits at index 0; the first sixteen steps rotate the line.
  always_comb begin
    if (ctrl.sched_idx < shabc_pkg::ROUND_W'(16)) begin
      sched_w = win[0];
    end else begin
      sched_w = shabc_pkg::small_sigma1(win[14]) + win[9]
              + shabc_pkg::small_sigma0(win[1]) + win[0];
    end
  end

  always_comb begin
    t1 = v[7] + shabc_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + wk;
    t2 = shabc_pkg::big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      win <= {word_in, win[15:1]};
    end else if (ctrl.init || ctrl.step) begin
      win <= {sched_w, win[15:1]};
      wk  <= sched_w + shabc_pkg::K_TABLE[ctrl.sched_idx];
    end
    if (ctrl.init) begin
      v <= chain;
    end else if (ctrl.step) begin
      v <= v_next;
    end
  end

  assign vars = v;

endmodule

[rtl/sha256_block_compression.sv]
// ----------------------------------------------------------------------------
// SHA-256 block compression engine
// Takes padded message words sixteen to a block, compresses each block into
// the chaining value and streams the eight digest words after a final block.
// ----------------------------------------------------------------------------
//  Channel   Signals                        Contents
//  s_*       s_tvalid s_tready s_tdata      message word, flags in s_tuser
//  m_*       m_tvalid m_tready m_tdata      digest word and index, m_tlast
//  cfg_*     cfg_valid cfg_ready            IV register index and data
//
//  Each word is taken in one cycle; after the sixteenth word of a block the
//  engine runs one schedule set-up, 64 rounds on the shared round datapath
//  and one fold into the chaining value, and is not ready meanwhile.
//  After a final block the eight digest words follow, one per m_tready cycle.
//  Reset loads the standard initial hash value into the IV registers and
//  clears the chaining value.
// ----------------------------------------------------------------------------
module sha256_block_compression (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // message_word
  input  logic [1:0]  s_tuser,   // first_block, final_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [shabc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PREP,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  state_t                        state;
  shabc_pkg::word_t              iv [shabc_pkg::NUM_IV];
  shabc_pkg::word8_t             chain;
  shabc_pkg::word8_t             vars;
  logic [shabc_pkg::POS_W-1:0]   pos;
  logic [shabc_pkg::ROUND_W-1:0] round_cnt;
  logic                          final_flag;
  logic [2:0]                    out_idx;
  logic                          in_fire;
  shabc_pkg::core_ctrl_t         ctrl;

  assign s_tready  = (state == S_LOAD);
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = (state == S_EMIT);
  assign m_tdata   = {5'b0, out_idx, chain[out_idx]};
  assign m_tlast   = (out_idx == 3'd7);

  always_comb begin
    ctrl.shift_in  = in_fire;
    ctrl.init      = (state == S_PREP);
    ctrl.step      = (state == S_ROUND);
    ctrl.sched_idx = (state == S_ROUND) ? round_cnt + 1'b1 : '0;
  end

  shabc_core u_core (
    .clk     (clk),
    .ctrl    (ctrl),
    .word_in (s_tdata),
    .chain   (chain),
    .vars    (vars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < shabc_pkg::NUM_IV; i++) begin
        iv[i] <= shabc_pkg::IV_RESET[i];
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < shabc_pkg::CFG_IDX_W'(shabc_pkg::NUM_IV)) begin
      iv[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      chain      <= '0;
      pos        <= '0;
      round_cnt  <= '0;
      final_flag <= 1'b0;
      out_idx    <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (pos == '0 && s_tuser[0]) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= iv[i];
              end
            end
            pos <= pos + 1'b1;
            if (pos == '1) begin
              final_flag <= s_tuser[1];
              state      <= S_PREP;
            end
          end
        end
        S_PREP: begin
          round_cnt <= '0;
          state     <= S_ROUND;
        end
        S_ROUND: begin
          round_cnt <= round_cnt + 1'b1;
          if (round_cnt == '1) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          out_idx <= '0;
          state   <= final_flag ? S_EMIT : S_LOAD;
        end
        S_EMIT: begin
          if (m_tready) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == 3'd7) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// SHA-256 block compression testbench
// Streams padded message blocks into the engine under several initial hash
// settings and idling patterns. Every accepted word updates a local SHA-256
// model, and each digest word leaving the engine is checked field by field
// against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 600;

  localparam logic [shabc_pkg::CFG_IDX_W-1:0] REG_IV0          = 8'd0;
  localparam logic [shabc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LOW = 8'd8;
  localparam logic [shabc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_TOP = 8'd255;

  localparam logic [64*32-1:0] SHA_ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [8*32-1:0] SHA_INITIAL_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    shabc_pkg::word_t digest;
    logic [2:0]       index;
    logic             last;
  } digest_word_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [31:0]                     s_tdata   = '0;   // message_word
  logic [1:0]                      s_tuser   = '0;   // first_block, final_block
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [39:0]                     m_tdata;          // digest_word, word_index, zero fill
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [shabc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                     cfg_data  = '0;

  shabc_pkg::word_t iv_regs [8];
  shabc_pkg::word_t chain_value [8];
  shabc_pkg::word_t schedule [16];
  logic [3:0]       word_pos;
  digest_word_t     digest_q [$];
  int               words_accepted;
  int               digests_predicted;
  int               error_count;
  int               src_idle_pct;
  int               sink_stall_pct;
  int               sink_hold_left;
  int               quiet_cycles;

  sha256_block_compression uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic shabc_pkg::word_t ror(shabc_pkg::word_t x, int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic void compress_into_chain();
    shabc_pkg::word_t v [8];
    shabc_pkg::word_t w, t1, t2, k;
    for (int i = 0; i < 8; i++) v[i] = chain_value[i];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        w = (ror(schedule[(r - 2) & 15], 17) ^ ror(schedule[(r - 2) & 15], 19)
             ^ (schedule[(r - 2) & 15] >> 10))
          + schedule[(r - 7) & 15]
          + (ror(schedule[(r - 15) & 15], 7) ^ ror(schedule[(r - 15) & 15], 18)
             ^ (schedule[(r - 15) & 15] >> 3))
          + schedule[r & 15];
        schedule[r & 15] = w;
      end else begin
        w = schedule[r & 15];
      end
      k  = SHA_ROUND_K[(63 - r) * 32 +: 32];
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_value[i] = chain_value[i] + v[i];
  endfunction

  function automatic void sha_predict_word(shabc_pkg::word_t msg, logic first_blk,
                                           logic final_blk);
    digest_word_t dw;
    if (word_pos == 4'd0 && first_blk) begin
      for (int i = 0; i < 8; i++) chain_value[i] = iv_regs[i];
    end
    schedule[word_pos] = msg;
    words_accepted++;
    if (word_pos == 4'd15) begin
      compress_into_chain();
      if (final_blk) begin
        for (int i = 0; i < 8; i++) begin
          dw.digest = chain_value[i];
          dw.index  = 3'(i);
          dw.last   = (i == 7);
          digest_q.push_back(dw);
          digests_predicted++;
        end
      end
    end
    word_pos = word_pos + 4'd1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] expected_v, logic [31:0] got_v);
    $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, expected_v, got_v);
    error_count++;
  endtask

  task automatic send_word(shabc_pkg::word_t msg, logic first_blk, logic final_blk);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= msg;
    s_tuser  <= {final_blk, first_blk};
    do @(posedge clk); while (!s_tready);
    sha_predict_word(msg, first_blk, final_blk);
  endtask

  task automatic write_iv_register(logic [shabc_pkg::CFG_IDX_W-1:0] idx,
                                   shabc_pkg::word_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < shabc_pkg::CFG_IDX_W'(shabc_pkg::NUM_IV)) iv_regs[idx[2:0]] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic shabc_pkg::word_t pick_message_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(31);
      3:       return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // Flags away from the first and last word of a block are random: the
  // engine must ignore them.
  task automatic send_block(logic first_blk, logic final_blk);
    for (int p = 0; p < 16; p++) begin
      send_word(pick_message_word(),
                (p == 0)  ? first_blk : 1'($urandom_range(1)),
                (p == 15) ? final_blk : 1'($urandom_range(1)));
    end
  endtask

  // Most messages are well formed; the rest miss the start flag, restart in
  // the middle or ask for a digest early.
  task automatic send_message();
    int  blocks;
    bit  well_formed;
    blocks      = $urandom_range(1, 2);
    well_formed = ($urandom_range(9) < 8);
    for (int b = 0; b < blocks; b++) begin
      send_block((b == 0)          ? (well_formed | 1'($urandom_range(1)))
                                   : (!well_formed & 1'($urandom_range(1))),
                 (b == blocks - 1) ? (well_formed | 1'($urandom_range(1)))
                                   : (!well_formed & 1'($urandom_range(1))));
    end
  endtask

  task automatic load_iv_set(int kind);
    shabc_pkg::word_t value;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0:       value = 32'h0000_0000;
        1:       value = 32'hffff_ffff;
        2:       value = $urandom;
        default: value = SHA_INITIAL_HASH[(7 - i) * 32 +: 32];
      endcase
      write_iv_register(REG_IV0 + shabc_pkg::CFG_IDX_W'(i), value);
    end
  endtask

  task automatic test_carried_zero_chain();
    shabc_pkg::word_t patterns [16];
    patterns = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                 32'haaaa_aaaa, 32'h5555_5555, 32'h7fff_ffff, 32'hfffe_ffff,
                 32'h0123_4567, 32'h89ab_cdef, 32'hf0f0_f0f0, 32'h0f0f_0f0f,
                 32'h6162_6380, 32'h0000_0000, 32'hdead_beef, 32'h0000_0018};
    // No start flag after reset, so the cleared chaining value is used.
    for (int p = 0; p < 16; p++) begin
      send_word(patterns[p], (p == 15) || (p % 3 == 1), (p == 15) || (p % 2 == 0));
    end
    wait_until_idle();
  endtask

  task automatic test_random_messages(int idle_kind, int iv_kind);
    int words_goal, digests_goal;
    case (idle_kind)
      0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1:       begin src_idle_pct = 61; sink_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  sink_stall_pct = 61; end
      default: begin src_idle_pct = 6;  sink_stall_pct = 6;  end
    endcase
    load_iv_set(iv_kind);
    words_goal   = words_accepted + 16;
    digests_goal = digests_predicted + 8;
    while (words_accepted < words_goal || digests_predicted < digests_goal) begin
      send_message();
    end
    wait_until_idle();
  endtask

  // The blocks of the following test start new messages, so they show
  // whether these writes left the IV registers alone.
  task automatic test_unmapped_registers();
    write_iv_register(REG_UNMAPPED_LOW, 32'hffff_ffff);
    write_iv_register(REG_UNMAPPED_TOP, 32'h0000_0000);
  endtask

  task automatic test_digest_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold_left = HOLD_CYCLES;
    for (int m = 0; m < 2; m++) send_block(1'b1, 1'b1);
    wait_until_idle();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold_left > 0) begin
      m_tready <= 1'b0;
      sink_hold_left = sink_hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", 32'h0, m_tdata[31:0]);
      end else begin
        want = digest_q.pop_front();
        if (m_tdata[31:0] !== want.digest)
          report_mismatch("digest_word", want.digest, m_tdata[31:0]);
        if (m_tdata[34:32] !== want.index)
          report_mismatch("word_index", 32'(want.index), 32'(m_tdata[34:32]));
        if (m_tlast !== want.last)
          report_mismatch("last", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      iv_regs[i]     = SHA_INITIAL_HASH[(7 - i) * 32 +: 32];
      chain_value[i] = '0;
    end
    for (int i = 0; i < 16; i++) schedule[i] = '0;
    word_pos          = '0;
    words_accepted    = 0;
    digests_predicted = 0;
    error_count       = 0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    sink_hold_left    = 0;
    quiet_cycles      = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_carried_zero_chain();
    test_random_messages(0, 0);
    test_random_messages(1, 1);
    test_random_messages(2, 2);
    test_random_messages(3, 3);
    test_unmapped_registers();
    test_digest_backpressure();

    if (error_count == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/shabc_pkg.sv
rtl/shabc_core.sv
rtl/sha256_block_compression.sv
test/testbench.sv
